// ===== sv/multi_task_watchdog_chain_macros.svh =====
// ----------------------------------------------------------------------------
// Watchdog chain assertion macros
// Shorthand for the concurrent checks of the watchdog chain block.
// ----------------------------------------------------------------------------
`ifndef MULTI_TASK_WATCHDOG_CHAIN_MACROS_SVH
`define MULTI_TASK_WATCHDOG_CHAIN_MACROS_SVH
`ifndef SYNTHESIS
`define MTWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watchdog chain check failed");
`define MTWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("watchdog chain check failed");
`else
`define MTWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MTWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mtwd_pkg.sv =====
// ----------------------------------------------------------------------------
// Watchdog chain package
// Command codes and field widths shared by the watchdog chain files.
// ----------------------------------------------------------------------------
package mtwd_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned MaskW = 32;
  localparam int unsigned CntW  = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_KICK  = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } mtwd_cmd_e;

endpackage

// ===== sv/mtwd_if.sv =====
// ----------------------------------------------------------------------------
// Watchdog chain channels
// Valid/ready channels for commands, results and the count register.
// ----------------------------------------------------------------------------
interface mtwd_cmd_if;
  import mtwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [IdxW-1:0]  index;
  logic [MaskW-1:0] start_mask;

  modport source (output valid, command, index, start_mask, input ready);
  modport sink   (input valid, command, index, start_mask, output ready);
endinterface

interface mtwd_res_if;
  import mtwd_pkg::*;

  logic             valid;
  logic             ready;
  logic             master_kick;
  logic             all_stopped;
  logic             range_error;
  logic [MaskW-1:0] kicked_now;
  logic [MaskW-1:0] active_now;

  modport source (output valid, master_kick, all_stopped, range_error, kicked_now,
                  active_now, input ready);
  modport sink   (input valid, master_kick, all_stopped, range_error, kicked_now,
                  active_now, output ready);
endinterface

interface mtwd_cfg_if;
  import mtwd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CntW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/mtwd_in_reg.sv =====
// ----------------------------------------------------------------------------
// Watchdog chain input register
// Registers one command word and passes it on when the next stage is free.
// ----------------------------------------------------------------------------
module mtwd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtwd_cmd_if.sink   in_i,
  mtwd_cmd_if.source out_o
);
  import mtwd_pkg::*;

  logic             vld_q, vld_d;
  logic [CmdW-1:0]  cmd_q;
  logic [IdxW-1:0]  idx_q;
  logic [MaskW-1:0] mask_q;
  logic             take;

  assign in_i.ready = !vld_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q  <= in_i.command;
      idx_q  <= in_i.index;
      mask_q <= in_i.start_mask;
    end
  end

  assign out_o.valid      = vld_q;
  assign out_o.command    = cmd_q;
  assign out_o.index      = idx_q;
  assign out_o.start_mask = mask_q;
endmodule

// ===== sv/mtwd_core.sv =====
// ----------------------------------------------------------------------------
// Watchdog chain core
// Holds the kicked, active and seen masks and the count register, applies one
// command per cycle unless the result stalls, and registers the result word.
// ----------------------------------------------------------------------------
module mtwd_core #(
  parameter int unsigned NUM_WATCHDOGS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtwd_cfg_if.sink   cfg_i,
  mtwd_cmd_if.sink   cmd_i,
  mtwd_res_if.source res_o
);
  import mtwd_pkg::*;

  localparam int unsigned W = (NUM_WATCHDOGS >= MaskW) ? MaskW : NUM_WATCHDOGS;

  logic [CntW-1:0]  count_q;
  logic [W-1:0]     kicked_q, kicked_d;
  logic [W-1:0]     active_q, active_d;
  logic [W-1:0]     seen_q, seen_d;
  logic             res_vld_q, res_vld_d;
  logic             mk_q, mk_d;
  logic             stop_q, stop_d;
  logic             err_q, err_d;
  logic             take;
  logic             idx_ok;
  logic [W-1:0]     sel;
  mtwd_cmd_e        cmd;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = !res_vld_q || res_o.ready;
  assign take        = cmd_i.valid && cmd_i.ready;
  assign cmd         = mtwd_cmd_e'(cmd_i.command);
  assign idx_ok      = ({1'b0, cmd_i.index} < count_q) &&
                       (32'(cmd_i.index) < NUM_WATCHDOGS);
  assign sel         = W'(1) << cmd_i.index;

  always_comb begin
    kicked_d = kicked_q;
    active_d = active_q;
    seen_d   = seen_q;
    mk_d     = 1'b0;
    stop_d   = 1'b0;
    err_d    = 1'b0;
    unique case (cmd)
      CMD_KICK: begin
        if (!idx_ok) begin
          err_d = 1'b1;
        end else begin
          kicked_d = kicked_q | sel;
          active_d = active_q | sel;
          seen_d   = seen_q | sel;
          if ((active_d & ~kicked_d) == '0) begin
            mk_d     = 1'b1;
            kicked_d = '0;
          end
        end
      end
      CMD_STOP: begin
        if (!idx_ok) begin
          err_d = 1'b1;
        end else begin
          active_d = active_q & ~sel;
          if ((seen_q & sel) != '0) begin
            if (active_d == '0) begin
              stop_d = 1'b1;
            end else if ((active_d & ~kicked_q) == '0) begin
              mk_d     = 1'b1;
              kicked_d = '0;
            end
          end
        end
      end
      CMD_START: begin
        active_d = active_q | cmd_i.start_mask[W-1:0];
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (take) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      kicked_q  <= '0;
      active_q  <= '0;
      seen_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
      if (cfg_i.valid) begin
        count_q <= cfg_i.data;
      end
      if (take) begin
        kicked_q <= kicked_d;
        active_q <= active_d;
        seen_q   <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mk_q   <= mk_d;
      stop_q <= stop_d;
      err_q  <= err_d;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.master_kick = mk_q;
  assign res_o.all_stopped = stop_q;
  assign res_o.range_error = err_q;
  assign res_o.kicked_now  = MaskW'(kicked_q);
  assign res_o.active_now  = MaskW'(active_q);
endmodule

// ===== sv/multi_task_watchdog_chain.sv =====
// ----------------------------------------------------------------------------
// Multi-task watchdog chain
// Combines many task watchdogs into one master kick.
// ----------------------------------------------------------------------------
// The block takes one command word per cycle unless the result output stalls,
// and returns one result word per command, which passes the input register
// and then the core; the core updates the kicked, active and seen masks and
// loads the result register in the same cycle. Up to 32 watchdogs are tracked;
// the count register must be written while no command is in flight.
`include "multi_task_watchdog_chain_macros.svh"

module multi_task_watchdog_chain #(
  parameter int unsigned NUM_WATCHDOGS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtwd_cfg_if.sink   cfg_i,
  mtwd_cmd_if.sink   cmd_i,
  mtwd_res_if.source res_o
);
  import mtwd_pkg::*;

  mtwd_cmd_if cmd_q_if ();

  mtwd_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_i),
    .out_o  (cmd_q_if.source)
  );

  mtwd_core #(
    .NUM_WATCHDOGS (NUM_WATCHDOGS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd_q_if.sink),
    .res_o  (res_o)
  );

  `MTWD_ASSERT_NOW(a_flags_exclusive, clk_i, rst_ni, res_o.valid, !(res_o.master_kick && res_o.all_stopped))
  `MTWD_ASSERT_NOW(a_error_quiet, clk_i, rst_ni, res_o.valid && res_o.range_error, !res_o.master_kick && !res_o.all_stopped)
  `MTWD_ASSERT_NOW(a_kick_clears, clk_i, rst_ni, res_o.valid && res_o.master_kick, res_o.kicked_now == '0)
  `MTWD_ASSERT_NOW(a_stop_empty, clk_i, rst_ni, res_o.valid && res_o.all_stopped, res_o.active_now == '0)
  `MTWD_ASSERT_NEXT(a_res_follows, clk_i, rst_ni, cmd_q_if.valid && cmd_q_if.ready, res_o.valid)
endmodule
